>>> rtl/lnpa_pkg.sv
// Shared types, codes and defaults for the linked node pool allocator.
package lnpa_pkg;

  // Default pool geometry.
  localparam int NODES_DEF    = 256;
  localparam int TAG_BITS_DEF = 16;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_COUNT = 3'd4;
  localparam logic [2:0] KIND_TEST  = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  // One input transaction.
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         addr;
    logic [15:0]        tag;
    logic signed [31:0] value;
    logic               last;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         node_addr;
    logic signed [31:0] read_value;
    logic [8:0]         free_count;
    logic               is_free;
  } out_t;

  // Decisions from the shared compare unit for one walk step.
  typedef struct packed {
    logic head_node;    // free head points at a real node
    logic addr_node;    // request address is a real node
    logic link_node;    // link of the current node points at a real node
    logic tag_hit;      // current node carries the requested tag
    logic addr_hit;     // current node is the requested address
    logic walk_more;    // step budget left for a tail walk
    logic search_more;  // step budget left for a search walk
  } step_flags_t;

endpackage

>>> rtl/lnpa_step.sv
// Shared compare unit: range checks, tag and address match, step budget.
module lnpa_step import lnpa_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic [$clog2(NODES+1)-1:0] free_head,
  input  logic [$clog2(NODES+1)-1:0] cur_node,
  input  logic [$clog2(NODES+1)-1:0] link_q,
  input  logic [$clog2(NODES+1)-1:0] steps,
  input  logic [TAG_BITS-1:0]        tag_q,
  input  logic [TAG_BITS-1:0]        tag_req,
  input  logic [7:0]                 addr_req,
  output step_flags_t                flags
);

  localparam int LW = $clog2(NODES + 1);
  localparam int XW = (LW > 8) ? LW : 8;

  // All comparisons share one set of comparators per step.
  always_comb begin
    flags.head_node   = free_head < LW'(NODES);
    flags.addr_node   = XW'(addr_req) < XW'(NODES);
    flags.link_node   = link_q < LW'(NODES);
    flags.tag_hit     = tag_q == tag_req;
    flags.addr_hit    = XW'(cur_node) == XW'(addr_req);
    flags.walk_more   = steps < LW'(NODES);
    flags.search_more = steps < LW'(NODES - 1);
  end

endmodule

>>> rtl/lnpa_seq.sv
// Sequencer with the node memories: clearing pass, allocation and list walks.
module lnpa_seq import lnpa_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic res_valid,
  input  logic res_ready,
  output out_t res_data
);

  localparam int AW = $clog2(NODES);
  localparam int LW = $clog2(NODES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_ISSUE   = 3'd2;
  localparam logic [2:0] S_WALK    = 3'd3;
  localparam logic [2:0] S_AL_WR   = 3'd4;
  localparam logic [2:0] S_AL_TAIL = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  // Node memories and their registered read data.
  logic [LW-1:0]       link_mem [NODES];
  logic [TAG_BITS-1:0] tag_mem  [NODES];
  logic [31:0]         val_mem  [NODES];
  logic [LW-1:0]       link_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [31:0]         val_q;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [LW-1:0]       free_head_r, free_head_nxt;
  logic                chain_open_r, chain_open_nxt;
  logic [AW-1:0]       chain_start_r, chain_start_nxt;
  logic [AW-1:0]       chain_tail_r, chain_tail_nxt;
  logic [LW-1:0]       x_r, x_nxt;
  logic [LW-1:0]       steps_r, steps_nxt;
  logic                hit_r, hit_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic [7:0]          addr_r, addr_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [31:0]         value_r, value_nxt;
  logic                last_r, last_nxt;
  out_t                res_r, res_nxt;

  logic [AW-1:0]       rd_addr;
  logic                link_we, tag_we, val_we;
  logic [AW-1:0]       link_wa, node_wa;
  logic [LW-1:0]       link_wd;
  logic [TAG_BITS-1:0] tag_wd;
  logic [31:0]         val_wd;
  logic [LW-1:0]       step_inc;
  logic                more;
  step_flags_t         fl;

  lnpa_step #(
    .NODES    (NODES),
    .TAG_BITS (TAG_BITS)
  ) u_step (
    .free_head (free_head_r),
    .cur_node  (x_r),
    .link_q    (link_q),
    .steps     (steps_r),
    .tag_q     (tag_q),
    .tag_req   (tag_r),
    .addr_req  (addr_r),
    .flags     (fl)
  );

  assign in_ready  = state_r == S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res_data  = res_r;
  assign step_inc  = steps_r + LW'(1);
  assign more      = fl.search_more && fl.link_node;

  // Node memories: one write per array and one shared read address per cycle.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (tag_we) begin
      tag_mem[node_wa] <= tag_wd;
    end
    if (val_we) begin
      val_mem[node_wa] <= val_wd;
    end
    link_q <= link_mem[rd_addr];
    tag_q  <= tag_mem[rd_addr];
    val_q  <= val_mem[rd_addr];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    free_head_nxt   = free_head_r;
    chain_open_nxt  = chain_open_r;
    chain_start_nxt = chain_start_r;
    chain_tail_nxt  = chain_tail_r;
    x_nxt           = x_r;
    steps_nxt       = steps_r;
    hit_nxt         = hit_r;
    kind_nxt        = kind_r;
    addr_nxt        = addr_r;
    tag_nxt         = tag_r;
    value_nxt       = value_r;
    last_nxt        = last_r;
    res_nxt         = res_r;
    rd_addr         = x_r[AW-1:0];
    link_we         = 1'b0;
    tag_we          = 1'b0;
    val_we          = 1'b0;
    link_wa         = x_r[AW-1:0];
    node_wa         = x_r[AW-1:0];
    link_wd         = NULL_LINK;
    tag_wd          = tag_r;
    val_wd          = value_r;

    unique case (state_r)
      // Bring every node to its reset contents, one entry per cycle.
      S_CLEAR: begin
        link_we = 1'b1;
        tag_we  = 1'b1;
        val_we  = 1'b1;
        link_wa = clr_r;
        node_wa = clr_r;
        link_wd = LW'(clr_r) + LW'(1);
        tag_wd  = '0;
        val_wd  = '0;
        if (clr_r == AW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      // Capture the transaction and clear the result.
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          addr_nxt  = in_data.addr;
          tag_nxt   = TAG_BITS'(in_data.tag);
          value_nxt = in_data.value;
          last_nxt  = in_data.last;
          res_nxt   = '0;
          hit_nxt   = 1'b0;
          steps_nxt = '0;
          state_nxt = S_ISSUE;
        end
      end

      // Pick the first node and launch its read.
      S_ISSUE: begin
        state_nxt = S_DONE;
        unique case (kind_r)
          KIND_ALLOC: begin
            if (fl.head_node) begin
              x_nxt     = free_head_r;
              rd_addr   = free_head_r[AW-1:0];
              state_nxt = S_AL_WR;
            end else begin
              res_nxt.status = ST_EMPTY;
            end
          end
          KIND_FREE, KIND_WRITE, KIND_READ: begin
            if (fl.addr_node) begin
              x_nxt     = LW'(addr_r);
              rd_addr   = AW'(addr_r);
              state_nxt = S_WALK;
            end else if (kind_r != KIND_FREE) begin
              res_nxt.status = ST_MISS;
              if (kind_r == KIND_READ) begin
                res_nxt.read_value = '1;
              end
            end
          end
          KIND_COUNT, KIND_TEST: begin
            if (fl.head_node) begin
              x_nxt     = free_head_r;
              rd_addr   = free_head_r[AW-1:0];
              state_nxt = S_WALK;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // One node per cycle: act on the current node and follow its link.
      S_WALK: begin
        x_nxt     = link_q;
        rd_addr   = link_q[AW-1:0];
        steps_nxt = step_inc;
        unique case (kind_r)
          KIND_FREE: begin
            if (!(fl.walk_more && fl.link_node)) begin
              state_nxt = S_DONE;
              if (!fl.link_node) begin
                link_we       = 1'b1;
                link_wd       = free_head_r;
                free_head_nxt = LW'(addr_r);
              end
            end
          end
          KIND_WRITE: begin
            if (fl.tag_hit) begin
              val_we  = 1'b1;
              hit_nxt = 1'b1;
            end
            if (!more) begin
              state_nxt      = S_DONE;
              res_nxt.status = (hit_r || fl.tag_hit) ? ST_OK : ST_MISS;
            end
          end
          KIND_READ: begin
            if (fl.tag_hit) begin
              res_nxt.read_value = val_q;
              state_nxt          = S_DONE;
            end else if (!more) begin
              res_nxt.status     = ST_MISS;
              res_nxt.read_value = '1;
              state_nxt          = S_DONE;
            end
          end
          KIND_COUNT: begin
            if (!more) begin
              res_nxt.free_count = 9'(step_inc);
              state_nxt          = S_DONE;
            end
          end
          KIND_TEST: begin
            if (fl.addr_hit) begin
              res_nxt.is_free = 1'b1;
              state_nxt       = S_DONE;
            end else if (!more) begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Take the free head: terminate it, store the tag, advance the head.
      S_AL_WR: begin
        free_head_nxt = link_q;
        link_we       = 1'b1;
        link_wd       = NULL_LINK;
        tag_we        = 1'b1;
        if (!chain_open_r) begin
          chain_start_nxt = x_r[AW-1:0];
          chain_tail_nxt  = x_r[AW-1:0];
        end
        chain_open_nxt = !last_r;
        if (last_r && chain_open_r) begin
          res_nxt.node_addr = 8'(chain_start_r);
        end else begin
          res_nxt.node_addr = 8'(x_r[AW-1:0]);
        end
        state_nxt = chain_open_r ? S_AL_TAIL : S_DONE;
      end

      // Join the new node behind the tail of the open chain.
      S_AL_TAIL: begin
        link_we        = 1'b1;
        link_wa        = chain_tail_r;
        link_wd        = x_r;
        chain_tail_nxt = x_r[AW-1:0];
        state_nxt      = S_DONE;
      end

      // Hold the result until the output stage takes it.
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      free_head_r   <= '0;
      chain_open_r  <= 1'b0;
      chain_start_r <= '0;
      chain_tail_r  <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      free_head_r   <= free_head_nxt;
      chain_open_r  <= chain_open_nxt;
      chain_start_r <= chain_start_nxt;
      chain_tail_r  <= chain_tail_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    steps_r <= steps_nxt;
    hit_r   <= hit_nxt;
    kind_r  <= kind_nxt;
    addr_r  <= addr_nxt;
    tag_r   <= tag_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  // An accepted transaction always starts with the issue cycle.
  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_ISSUE)
    else $error("accepted transaction did not enter issue");

  // The free head is either a node or the null link, never beyond.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLEAR |-> free_head_r <= NULL_LINK)
    else $error("free head out of range");

  // A waiting result is held unchanged until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_r))
    else $error("pending result changed");

  // A walk never runs past its step budget.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> steps_r <= LW'(NODES))
    else $error("walk exceeded step budget");

endmodule

>>> rtl/linked_node_pool_allocator.sv
// Top level of the linked node pool allocator: sequencer and output register.
//
// Usage: one input channel (in_valid, in_ready, in_data) carries requests:
// allocate, free chain, write, read, count free and test free. Each request
// produces exactly one transaction on the result channel (out_valid,
// out_ready, out_data). There is no configuration port.
// Allocate passes through issue, write and done states, with a tail-join
// state between write and done when a chain is already open; free, write,
// read, count and test free walk the list. The walk follows one link per
// cycle through the single read port of the node memories.
// One request is in flight at a time; in_ready is high only when idle.
// After reset the block runs a clearing pass that rebuilds the free list
// and blanks tags and values; in_ready stays low meanwhile.
// A finished result sits in the output register while the next request is
// accepted and worked on; if the receiver stalls, the sequencer holds its
// next result until the output register frees up, then returns to idle.
module linked_node_pool_allocator import lnpa_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_r;
  logic res_valid;
  logic res_ready;
  out_t res_data;

  lnpa_seq #(
    .NODES    (NODES),
    .TAG_BITS (TAG_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res_data;
    end
  end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the linked node pool allocator.
`timescale 1ns / 100ps

module tb_top;
  import lnpa_pkg::*;

  localparam int POOL = NODES_DEF;
  localparam logic [8:0] NULL_LINK = 9'(NODES_DEF);
  localparam logic signed [31:0] MISS_VALUE = -1;
  localparam int LIMIT = 2_000_000;
  localparam int TOTAL_ITEMS = 1350;
  localparam int PHASES = 4;

  // Kind codes that the block ignores.
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Shadow copy of the pool.
  logic [8:0]  pool_link [POOL];
  logic [15:0] pool_tag [POOL];
  logic [31:0] pool_value [POOL];
  logic [8:0]  pool_free_head;
  logic        chain_open;
  logic [7:0]  chain_start;
  logic [8:0]  chain_tail;

  out_t        pending_results[$];
  step_row_t   directed_rows[$];
  logic [7:0]  live_heads[$];
  int          mismatches;
  int          issued;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  linked_node_pool_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("** linked_node_pool_allocator: FAILED **");
      $finish;
    end
  end

  function automatic bit is_cell(logic [8:0] a);
    return int'(a) < POOL;
  endfunction

  // Computes the result of one request and updates the shadow pool.
  function automatic out_t predict_pool_result(in_t req);
    out_t       res;
    logic [8:0] x;
    logic [8:0] d;
    int         steps;
    bit         hit;
    res = '0;
    x = {1'b0, req.addr};
    steps = 0;
    hit = 1'b0;
    case (req.kind)
      KIND_ALLOC: begin
        if (!is_cell(pool_free_head)) begin
          res.status = ST_EMPTY;
        end else begin
          d = pool_free_head;
          pool_free_head = pool_link[d];
          pool_tag[d] = req.tag;
          pool_link[d] = NULL_LINK;
          if (chain_open) begin
            if (is_cell(chain_tail)) pool_link[chain_tail] = d;
          end else begin
            chain_start = d[7:0];
          end
          chain_tail = d;
          if (req.last) begin
            chain_open = 1'b0;
            res.node_addr = chain_start;
          end else begin
            chain_open = 1'b1;
            res.node_addr = d[7:0];
          end
        end
      end
      KIND_FREE: begin
        if (is_cell(x)) begin
          // Walk to the tail; a cyclic chain never reaches one.
          while (steps < POOL && is_cell(pool_link[x])) begin
            x = pool_link[x];
            steps++;
          end
          if (!is_cell(pool_link[x])) begin
            pool_link[x] = pool_free_head;
            pool_free_head = {1'b0, req.addr};
          end
        end
      end
      KIND_WRITE: begin
        while (steps < POOL && is_cell(x)) begin
          if (pool_tag[x] == req.tag) begin
            pool_value[x] = req.value;
            hit = 1'b1;
          end
          x = pool_link[x];
          steps++;
        end
        if (!hit) res.status = ST_MISS;
      end
      KIND_READ: begin
        while (!hit && steps < POOL && is_cell(x)) begin
          if (pool_tag[x] == req.tag) begin
            res.read_value = pool_value[x];
            hit = 1'b1;
          end else begin
            x = pool_link[x];
            steps++;
          end
        end
        if (!hit) begin
          res.status = ST_MISS;
          res.read_value = MISS_VALUE;
        end
      end
      KIND_COUNT: begin
        x = pool_free_head;
        while (steps < POOL && is_cell(x)) begin
          steps++;
          x = pool_link[x];
        end
        res.free_count = 9'(steps);
      end
      KIND_TEST: begin
        x = pool_free_head;
        while (!hit && steps < POOL && is_cell(x)) begin
          if (x == {1'b0, req.addr}) hit = 1'b1;
          else x = pool_link[x];
          steps++;
        end
        res.is_free = hit;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_t mk_req(logic [2:0] kind, logic [7:0] addr, logic [15:0] tag,
                                 logic signed [31:0] value, logic last);
    in_t r;
    r.kind = kind;
    r.addr = addr;
    r.tag = tag;
    r.value = value;
    r.last = last;
    return r;
  endfunction

  function automatic out_t mk_res(logic [1:0] status, logic [7:0] node_addr,
                                  logic signed [31:0] read_value, logic [8:0] free_count,
                                  logic is_free);
    out_t r;
    r.status = status;
    r.node_addr = node_addr;
    r.read_value = read_value;
    r.free_count = free_count;
    r.is_free = is_free;
    return r;
  endfunction

  task automatic add_row(in_t req, bit typed, out_t want);
    step_row_t row;
    row.req = req;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Follows up to hops links from a chain head in the shadow pool.
  function automatic logic [8:0] walk_chain(logic [7:0] head, int hops);
    logic [8:0] x;
    x = {1'b0, head};
    for (int i = 0; i < hops; i++) begin
      if (is_cell(pool_link[x])) x = pool_link[x];
    end
    return x;
  endfunction

  // Tags lean toward a few values so that chains carry repeated tags.
  function automatic logic [15:0] pick_tag();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 7));
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(11))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return -1;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_head();
    if (live_heads.size() != 0 && $urandom_range(99) < 85)
      return live_heads[$urandom_range(live_heads.size() - 1)];
    return 8'($urandom);
  endfunction

  // Drives one transaction, predicts it on acceptance and queues the expectation.
  task automatic issue_request(input in_t req, input bit has_typed, input out_t typed_res,
                               output out_t pred);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_pool_result(req);
    pending_results.push_back(has_typed ? typed_res : pred);
    issued++;
    if (req.kind == KIND_ALLOC && req.last && pred.status == ST_OK)
      live_heads.push_back(pred.node_addr);
    @(negedge clk);
  endtask

  task automatic send(in_t req);
    out_t pred;
    issue_request(req, 1'b0, '0, pred);
  endtask

  task automatic build_chain(int len);
    for (int i = 0; i < len; i++) send(mk_req(KIND_ALLOC, 8'($urandom), pick_tag(),
                                              pick_value(), i == len - 1));
  endtask

  task automatic free_live_chain();
    int idx;
    logic [7:0] head;
    idx = $urandom_range(live_heads.size() - 1);
    head = live_heads[idx];
    // Now and then the head stays listed, so it gets freed twice later.
    if ($urandom_range(99) >= 3) live_heads.delete(idx);
    send(mk_req(KIND_FREE, head, pick_tag(), pick_value(), 1'($urandom_range(1))));
  endtask

  // Empties the pool with one long chain, then gives the nodes back.
  task automatic drain_pool();
    out_t       pred;
    logic [7:0] first_node;
    issue_request(mk_req(KIND_ALLOC, 8'($urandom), pick_tag(), pick_value(), 1'b0),
                  1'b0, '0, pred);
    first_node = pred.node_addr;
    for (int i = 0; i < POOL + 4 && is_cell(pool_free_head); i++)
      send(mk_req(KIND_ALLOC, 8'($urandom), pick_tag(), pick_value(), 1'b0));
    send(mk_req(KIND_ALLOC, 8'($urandom), pick_tag(), pick_value(), 1'b0));
    send(mk_req(KIND_ALLOC, 8'($urandom), pick_tag(), pick_value(), 1'b1));
    send(mk_req(KIND_COUNT, 8'($urandom), pick_tag(), pick_value(), 1'b0));
    if (live_heads.size() != 0) free_live_chain();
    issue_request(mk_req(KIND_ALLOC, 8'($urandom), pick_tag(), pick_value(), 1'b1),
                  1'b0, '0, pred);
    if (pred.status == ST_OK) begin
      void'(live_heads.pop_back());
      send(mk_req(KIND_FREE, pred.node_addr, pick_tag(), pick_value(), 1'b0));
    end else begin
      send(mk_req(KIND_FREE, first_node, pick_tag(), pick_value(), 1'b0));
    end
  endtask

  // One random burst of well-formed traffic, with some noise mixed in.
  task automatic random_burst();
    int         sel;
    logic [7:0] head;
    logic [15:0] tag;
    sel = $urandom_range(99);
    if (live_heads.size() > 24) sel = 76;
    head = pick_head();
    tag = ($urandom_range(99) < 80) ? pool_tag[walk_chain(head, $urandom_range(7))]
                                    : pick_tag();
    if (sel < 28 || (sel >= 74 && sel < 84 && live_heads.size() == 0)) begin
      build_chain(($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6));
    end else if (sel < 52) begin
      send(mk_req(KIND_WRITE, head, tag, pick_value(), 1'($urandom_range(1))));
    end else if (sel < 74) begin
      send(mk_req(KIND_READ, head, tag, pick_value(), 1'($urandom_range(1))));
    end else if (sel < 84) begin
      free_live_chain();
    end else if (sel < 88) begin
      send(mk_req(KIND_COUNT, 8'($urandom), pick_tag(), pick_value(),
                  1'($urandom_range(1))));
    end else if (sel < 95) begin
      head = $urandom_range(1) ? 8'(walk_chain(head, $urandom_range(7))) : 8'($urandom);
      send(mk_req(KIND_TEST, head, pick_tag(), pick_value(), 1'($urandom_range(1))));
    end else begin
      send(mk_req(3'($urandom_range(7)), 8'($urandom), 16'($urandom), $urandom,
                  1'($urandom_range(1))));
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(out_data), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.node_addr !== want.node_addr)
          report_mismatch("node_addr", out_data.node_addr, want.node_addr);
        if (out_data.read_value !== want.read_value)
          report_mismatch("read_value", 32'(out_data.read_value), 32'(want.read_value));
        if (out_data.free_count !== want.free_count)
          report_mismatch("free_count", out_data.free_count, want.free_count);
        if (out_data.is_free !== want.is_free)
          report_mismatch("is_free", out_data.is_free, want.is_free);
      end
    end
  end

  initial begin : stimulus
    out_t pred;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatches = 0;
    issued = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // Shadow pool after reset: every node on the free list, in order.
    for (int i = 0; i < POOL; i++) begin
      pool_link[i] = (i + 1 < POOL) ? 9'(i + 1) : NULL_LINK;
      pool_tag[i] = '0;
      pool_value[i] = '0;
    end
    pool_free_head = '0;
    chain_open = 1'b0;
    chain_start = '0;
    chain_tail = '0;

    // Directed rows: fresh pool, a three-node chain, misses, ignored kinds,
    // a double free that makes the free list cyclic, and its repair.
    add_row(mk_req(KIND_COUNT, 8'h00, 16'h0000, 0, 1'b0), 1, mk_res(ST_OK, 0, 0, 9'd256, 0));
    add_row(mk_req(KIND_TEST, 8'h00, 16'h0000, 0, 1'b0), 1, mk_res(ST_OK, 0, 0, 0, 1));
    add_row(mk_req(KIND_TEST, 8'hFF, 16'hFFFF, 0, 1'b1), 1, mk_res(ST_OK, 0, 0, 0, 1));
    add_row(mk_req(KIND_READ, 8'h00, 16'h1234, 0, 1'b0), 1,
            mk_res(ST_MISS, 0, MISS_VALUE, 0, 0));
    add_row(mk_req(KIND_READ, 8'h05, 16'h0000, 0, 1'b0), 1, mk_res(ST_OK, 0, 0, 0, 0));
    add_row(mk_req(KIND_ALLOC, 8'h00, 16'hFFFF, 0, 1'b0), 1, mk_res(ST_OK, 8'd0, 0, 0, 0));
    add_row(mk_req(KIND_ALLOC, 8'hFF, 16'h0000, 0, 1'b0), 1, mk_res(ST_OK, 8'd1, 0, 0, 0));
    add_row(mk_req(KIND_ALLOC, 8'h00, 16'hA5A5, 0, 1'b1), 1, mk_res(ST_OK, 8'd0, 0, 0, 0));
    add_row(mk_req(KIND_WRITE, 8'h00, 16'hFFFF, 32'sh7FFFFFFF, 1'b0), 0, '0);
    add_row(mk_req(KIND_WRITE, 8'h00, 16'hA5A5, 32'sh80000000, 1'b0), 0, '0);
    add_row(mk_req(KIND_WRITE, 8'h00, 16'h0001, 0, 1'b0), 1, mk_res(ST_MISS, 0, 0, 0, 0));
    add_row(mk_req(KIND_READ, 8'h00, 16'hFFFF, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_READ, 8'h00, 16'hA5A5, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_READ, 8'h00, 16'h0000, -1, 1'b1), 0, '0);
    add_row(mk_req(KIND_COUNT, 8'hFF, 16'hFFFF, -1, 1'b1), 0, '0);
    add_row(mk_req(KIND_TEST, 8'h01, 16'h0000, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_TEST, 8'h03, 16'h0000, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_SPARE6, 8'hFF, 16'hFFFF, -1, 1'b1), 1, mk_res(ST_OK, 0, 0, 0, 0));
    add_row(mk_req(KIND_SPARE7, 8'hFF, 16'hFFFF, -1, 1'b1), 1, mk_res(ST_OK, 0, 0, 0, 0));
    add_row(mk_req(KIND_FREE, 8'h00, 16'h0000, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_TEST, 8'h02, 16'h0000, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_FREE, 8'h00, 16'h0000, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_COUNT, 8'h00, 16'h0000, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_FREE, 8'h05, 16'h0000, 0, 1'b0), 0, '0);
    add_row(mk_req(KIND_ALLOC, 8'h00, 16'h0007, 0, 1'b1), 0, '0);

    // Hold reset, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, pred);

    // Random traffic in four phases of varied idling and stalls; two phases start by emptying the pool.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (phase == 0 || phase == 3) drain_pool();
      while (issued < directed_rows.size() +
             (phase + 1) * (TOTAL_ITEMS - directed_rows.size()) / PHASES)
        random_burst();
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then for stray extra ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (POOL + 8) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** linked_node_pool_allocator: PASSED **");
    end else begin
      $display("** linked_node_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule

>>> linked_node_pool_allocator.f
rtl/lnpa_pkg.sv
rtl/lnpa_step.sv
rtl/lnpa_seq.sv
rtl/linked_node_pool_allocator.sv
dv/tb_top.sv
